/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/rmvs_pkg.sv */
// Package: widths, limits and sequencer states of the running statistics block.
`timescale 1ns / 1ps
`default_nettype none
package rmvs_pkg;
    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
    localparam int DVD_BITS    = 80;
    localparam int DVS_BITS    = 40;
    localparam int QUO_BITS    = 64;
    localparam int SQ_BITS     = 64;
    localparam int ROOT_BITS   = 32;
    localparam int PCT_BITS    = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_MDIV_GO   = 11'b000_0000_0010,
        S_MDIV_WAIT = 11'b000_0000_0100,
        S_MUL_GO    = 11'b000_0000_1000,
        S_MUL_WAIT  = 11'b000_0001_0000,
        S_SD_GO     = 11'b000_0010_0000,
        S_SD_WAIT   = 11'b000_0100_0000,
        S_SQ_WAIT   = 11'b000_1000_0000,
        S_PCT_GO    = 11'b001_0000_0000,
        S_PCT_WAIT  = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } rmvs_state_t;
endpackage
`default_nettype wire

/* rtl/rmvs_div.sv */
// Shared restoring divider: 80-bit dividend, 40-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rmvs_div
    import rmvs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DVD_BITS-1:0] dividend,
    input  wire logic [DVS_BITS-1:0] divisor,
    output logic                     done,
    output logic [QUO_BITS-1:0]      quotient,
    output logic                     over
);
    logic [DVD_BITS-1:0] dvd_reg;
    logic [DVS_BITS-1:0] dvs_reg;
    logic [DVS_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic                over_reg;
    logic [6:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DVS_BITS:0]   rem_sh;
    logic                fits;

    // remainder stays below the divisor, so it fits in DVS_BITS
    assign rem_sh = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DVD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
            over_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[DVD_BITS-2:0], 1'b0};
            over_reg <= over_reg | quo_reg[QUO_BITS-1];
            quo_reg  <= {quo_reg[QUO_BITS-2:0], fits};
            rem_reg  <= fits ? DVS_BITS'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign over     = over_reg;
endmodule
`default_nettype wire

/* rtl/rmvs_mul.sv */
// Shift-add multiplier, 40 x 40 bits, one bit of the multiplier per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rmvs_mul
    import rmvs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MEAN_BITS-1:0] a,
    input  wire logic [MEAN_BITS-1:0] b,
    output logic                      done,
    output logic [2*MEAN_BITS-1:0]    prod
);
    logic [2*MEAN_BITS-1:0] acc_reg;
    logic [2*MEAN_BITS-1:0] a_reg;
    logic [MEAN_BITS-1:0]   b_reg;
    logic [5:0]             cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(MEAN_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= {{MEAN_BITS{1'b0}}, a};
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= {a_reg[2*MEAN_BITS-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MEAN_BITS-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

/* rtl/rmvs_sqrt.sv */
// Integer square root of a 64-bit word, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rmvs_sqrt
    import rmvs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [SQ_BITS-1:0] x,
    output logic                    done,
    output logic [ROOT_BITS-1:0]    root
);
    logic [SQ_BITS-1:0] x_reg;
    logic [SQ_BITS-1:0] res_reg;
    logic [SQ_BITS-1:0] bit_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SQ_BITS-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            res_reg <= '0;
            bit_reg <= {2'b01, {(SQ_BITS-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= {1'b0, res_reg[SQ_BITS-1:1]} + bit_reg;
            end
            else
            begin
                res_reg <= {1'b0, res_reg[SQ_BITS-1:1]};
            end
            bit_reg <= {2'b00, bit_reg[SQ_BITS-1:2]};
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_BITS-1:0];
endmodule
`default_nettype wire

/* rtl/running_mean_variance_stats.sv */
// Top level: running count, mean, variance, min and max of a sample stream.
`timescale 1ns / 1ps
`default_nettype none
// Running statistics over unsigned 24-bit samples. Each accepted word yields
// one result word with the count, the Welford running mean (Q24.16), min,
// max, the standard deviation of the mean (Q24.8, zero below two samples) and
// the relative deviation in percent (Q8.8, zero when the mean is zero). Once
// the count reaches 65535 further samples are dropped and count_saturated is
// set. One word is in work at a time; in_stall stays high until its result
// sits in the output register. Per sample the shared 80-step divider runs up to
// three times (mean step, scaled variance, percentage), the 40-step shift-add
// multiplier once and the 32-step square root once, with sequencer states
// between them; a saturated sample skips the mean divide and the multiply, a
// count below two skips the variance divide and the square root, and a zero
// mean skips the percentage divide. The output register frees the input side,
// so a new word may be accepted while a result waits on out_stall.
module running_mean_variance_stats
    import rmvs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [COUNT_BITS-1:0]       sample_count,
    output logic [MEAN_BITS-1:0]        mean_value,
    output logic [SAMPLE_BITS-1:0]      min_value,
    output logic [SAMPLE_BITS-1:0]      max_value,
    output logic [ROOT_BITS-1:0]        stddev_of_mean,
    output logic [PCT_BITS-1:0]         relative_stddev_pct,
    output logic                        count_saturated
);
    rmvs_state_t state_reg;

    // statistics state
    logic [COUNT_BITS-1:0]  count_reg;
    logic [MEAN_BITS-1:0]   mean_reg;
    logic [SQ_BITS-1:0]     sq_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;

    // per-word working registers
    logic [MEAN_BITS-1:0]   v_reg;
    logic [MEAN_BITS-1:0]   mag_reg;
    logic                   up_reg;
    logic                   sat_reg;
    logic [ROOT_BITS-1:0]   sd_reg;
    logic [PCT_BITS-1:0]    pct_reg;

    // output register
    logic                   out_valid_reg;
    logic [COUNT_BITS-1:0]  o_count_reg;
    logic [MEAN_BITS-1:0]   o_mean_reg;
    logic [SAMPLE_BITS-1:0] o_min_reg;
    logic [SAMPLE_BITS-1:0] o_max_reg;
    logic [ROOT_BITS-1:0]   o_sd_reg;
    logic [PCT_BITS-1:0]    o_pct_reg;
    logic                   o_sat_reg;

    logic                   accept;
    logic                   out_free;
    logic [MEAN_BITS-1:0]   v_in;
    logic                   up_in;
    logic                   sat_in;

    logic                   div_start;
    logic [DVD_BITS-1:0]    div_dvd;
    logic [DVS_BITS-1:0]    div_dvs;
    logic                   div_done;
    logic [QUO_BITS-1:0]    div_q;
    logic                   div_over;

    logic                   mul_start;
    logic [MEAN_BITS-1:0]   f2;
    logic                   mul_done;
    logic [2*MEAN_BITS-1:0] mul_prod;

    logic                   sq_start;
    logic [SQ_BITS-1:0]     sq_arg;
    logic                   sq_done;
    logic [ROOT_BITS-1:0]   sq_root;

    logic [2*COUNT_BITS-1:0] pair_prod;
    logic [SQ_BITS-1:0]      incr;
    logic [SQ_BITS:0]        sq_sum;
    logic [MEAN_BITS-1:0]    mean_new;
    logic [ROOT_BITS+6:0]    sd_x100;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign v_in   = {sample, {FRAC_BITS{1'b0}}};
    assign up_in  = v_in >= mean_reg;
    assign sat_in = (count_reg == COUNT_MAX);

    // (n-1)*n for the variance divisor
    assign pair_prod = {{COUNT_BITS{1'b0}}, count_reg - COUNT_BITS'(1)}
                     * {{COUNT_BITS{1'b0}}, count_reg};
    assign sd_x100   = (ROOT_BITS+7)'(sd_reg) * (ROOT_BITS+7)'(100);

    // deviation from the updated mean
    assign f2 = up_reg ? (v_reg - mean_reg) : (mean_reg - v_reg);

    // product is below 2^80, so the Q.32 floor never saturates
    assign incr   = SQ_BITS'(mul_prod[2*MEAN_BITS-1:32]);
    assign sq_sum = {1'b0, sq_reg} + {1'b0, incr};

    assign mean_new = up_reg ? (mean_reg + div_q[MEAN_BITS-1:0])
                             : (mean_reg - div_q[MEAN_BITS-1:0]);

    assign sq_arg = div_over ? {SQ_BITS{1'b1}} : div_q;

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        mul_start = (state_reg == S_MUL_GO);
        sq_start  = (state_reg == S_SD_WAIT) && div_done;
        unique case (state_reg)
            S_MDIV_GO:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_BITS'(mag_reg);
                div_dvs   = DVS_BITS'(count_reg);
            end
            S_SD_GO:
            begin
                div_start = (count_reg >= COUNT_BITS'(2));
                div_dvd   = {sq_reg, {FRAC_BITS{1'b0}}};
                div_dvs   = DVS_BITS'(pair_prod);
            end
            S_PCT_GO:
            begin
                div_start = (mean_reg != '0);
                div_dvd   = DVD_BITS'({sd_x100, {FRAC_BITS{1'b0}}});
                div_dvs   = DVS_BITS'(mean_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    rmvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q),
        .over     (div_over)
    );

    rmvs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag_reg),
        .b     (f2),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    rmvs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (sq_arg),
        .done  (sq_done),
        .root  (sq_root)
    );

    // sequencer and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mean_reg      <= '0;
            sq_reg        <= '0;
            min_reg       <= {SAMPLE_BITS{1'b1}};
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // S_DONE reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (sat_in)
                        begin
                            state_reg <= S_SD_GO;
                        end
                        else
                        begin
                            count_reg <= count_reg + COUNT_BITS'(1);
                            if (sample > max_reg)
                                max_reg <= sample;
                            if (sample < min_reg)
                                min_reg <= sample;
                            state_reg <= S_MDIV_GO;
                        end
                    end
                end
                S_MDIV_GO:
                begin
                    state_reg <= S_MDIV_WAIT;
                end
                S_MDIV_WAIT:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= mean_new;
                        state_reg <= S_MUL_GO;
                    end
                end
                S_MUL_GO:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= sq_sum[SQ_BITS] ? {SQ_BITS{1'b1}} : sq_sum[SQ_BITS-1:0];
                        state_reg <= S_SD_GO;
                    end
                end
                S_SD_GO:
                begin
                    state_reg <= (count_reg >= COUNT_BITS'(2)) ? S_SD_WAIT : S_PCT_GO;
                end
                S_SD_WAIT:
                begin
                    if (div_done)
                        state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT:
                begin
                    if (sq_done)
                        state_reg <= S_PCT_GO;
                end
                S_PCT_GO:
                begin
                    state_reg <= (mean_reg != '0) ? S_PCT_WAIT : S_DONE;
                end
                S_PCT_WAIT:
                begin
                    if (div_done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg   <= v_in;
            up_reg  <= up_in;
            mag_reg <= up_in ? (v_in - mean_reg) : (mean_reg - v_in);
            sat_reg <= sat_in;
            sd_reg  <= '0;
            pct_reg <= '0;
        end
        if (state_reg == S_SQ_WAIT && sq_done)
            sd_reg <= sq_root;
        if (state_reg == S_PCT_WAIT && div_done)
        begin
            if (div_over || (div_q > QUO_BITS'(16'hFFFF)))
                pct_reg <= '1;
            else
                pct_reg <= div_q[PCT_BITS-1:0];
        end
        if (state_reg == S_DONE && out_free)
        begin
            o_count_reg <= count_reg;
            o_mean_reg  <= mean_reg;
            o_min_reg   <= min_reg;
            o_max_reg   <= max_reg;
            o_sd_reg    <= sd_reg;
            o_pct_reg   <= pct_reg;
            o_sat_reg   <= sat_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign sample_count        = o_count_reg;
    assign mean_value          = o_mean_reg;
    assign min_value           = o_min_reg;
    assign max_value           = o_max_reg;
    assign stddev_of_mean      = o_sd_reg;
    assign relative_stddev_pct = o_pct_reg;
    assign count_saturated     = o_sat_reg;
endmodule
`default_nettype wire

/* rtl/rmvs_checker.sv */
// Port-level checker for the running statistics block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rmvs_checker
    import rmvs_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [COUNT_BITS-1:0] sample_count,
    input wire logic [ROOT_BITS-1:0]  stddev_of_mean,
    input wire logic                  count_saturated
);
    // a result held back stays offered
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // one word in work at a time
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // a dropped word only happens at the count limit
    `ASSERT_IMPL(a_sat_at_limit, out_valid && count_saturated, sample_count == COUNT_MAX)
    // no deviation below two samples
    `ASSERT_IMPL(a_sd_low_count, out_valid && (sample_count < COUNT_BITS'(2)),
                 stddev_of_mean == '0)
endmodule

bind running_mean_variance_stats rmvs_checker u_rmvs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sample_count    (sample_count),
    .stddev_of_mean  (stddev_of_mean),
    .count_saturated (count_saturated)
);
`default_nettype wire

/* verif/running_mean_variance_stats_test.sv */
// Testbench for the running statistics block: directed and random samples, self-checking.
`timescale 1ns / 1ps
module running_mean_variance_stats_test;
    import rmvs_pkg::*;

    // Both sides may stall, so the limit is taken with a wide margin.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 600;
    localparam int RANDOM_PER_PHASE = 275;

    typedef struct {
        logic [COUNT_BITS-1:0]  count;
        logic [MEAN_BITS-1:0]   mean;
        logic [SAMPLE_BITS-1:0] min;
        logic [SAMPLE_BITS-1:0] max;
        logic [ROOT_BITS-1:0]   sd;
        logic [PCT_BITS-1:0]    pct;
        logic                   sat;
    } stats_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [COUNT_BITS-1:0]  sample_count;
    logic [MEAN_BITS-1:0]   mean_value;
    logic [SAMPLE_BITS-1:0] min_value;
    logic [SAMPLE_BITS-1:0] max_value;
    logic [ROOT_BITS-1:0]   stddev_of_mean;
    logic [PCT_BITS-1:0]    relative_stddev_pct;
    logic                   count_saturated;

    // Shadow copy of the statistics state
    logic [COUNT_BITS-1:0]  run_count;
    logic [MEAN_BITS-1:0]   run_mean;
    logic [63:0]            run_m2;
    logic [SAMPLE_BITS-1:0] run_min;
    logic [SAMPLE_BITS-1:0] run_max;

    stats_word_t pending_stats[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    running_mean_variance_stats uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .sample              (sample),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .sample_count        (sample_count),
        .mean_value          (mean_value),
        .min_value           (min_value),
        .max_value           (max_value),
        .stddev_of_mean      (stddev_of_mean),
        .relative_stddev_pct (relative_stddev_pct),
        .count_saturated     (count_saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Floored integer square root, bit-pair method.
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Fold one sample into the shadow state (Welford step) and return
    // the statistics word the block should report for it.
    function automatic stats_word_t fold_sample(input logic [SAMPLE_BITS-1:0] val);
        stats_word_t res;
        logic [MEAN_BITS-1:0] v;
        logic [MEAN_BITS-1:0] mag;
        logic [MEAN_BITS-1:0] stepv;
        logic [MEAN_BITS-1:0] f2;
        logic                 up;
        logic [79:0]          prod;
        logic [63:0]          incr;
        logic [64:0]          m2_sum;
        logic [31:0]          dv;
        logic [79:0]          quo;
        logic [63:0]          q;
        logic [63:0]          sd;
        logic [79:0]          pct;
        res.sat = 1'b0;
        sd      = '0;
        pct     = '0;
        if (run_count == COUNT_MAX)
            res.sat = 1'b1;  // dropped, state unchanged
        else
        begin
            v         = {val, {FRAC_BITS{1'b0}}};
            up        = v >= run_mean;
            mag       = up ? v - run_mean : run_mean - v;
            run_count = run_count + 1'b1;
            stepv     = mag / {{(MEAN_BITS-COUNT_BITS){1'b0}}, run_count};
            run_mean  = up ? run_mean + stepv : run_mean - stepv;
            f2        = up ? v - run_mean : run_mean - v;
            prod      = {40'b0, mag} * {40'b0, f2};
            incr      = 64'(prod[79:32]);
            m2_sum    = {1'b0, run_m2} + {1'b0, incr};
            run_m2    = m2_sum[64] ? '1 : m2_sum[63:0];
            if (val > run_max)
                run_max = val;
            if (val < run_min)
                run_min = val;
        end
        if (run_count >= 2)
        begin
            dv  = {16'b0, run_count - 1'b1} * {16'b0, run_count};
            quo = {run_m2, 16'b0} / {48'b0, dv};
            q   = (quo[79:64] != 0) ? '1 : quo[63:0];
            sd  = int_sqrt(q);
        end
        if (run_mean != 0)
        begin
            pct = ({16'b0, sd} * 80'd100 << 16) / {40'b0, run_mean};
            if (pct > 80'hFFFF)
                pct = 80'hFFFF;
        end
        res.count = run_count;
        res.mean  = run_mean;
        res.min   = run_min;
        res.max   = run_max;
        res.sd    = sd[31:0];
        res.pct   = pct[15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // Send one word; the expectation is queued when the block takes it.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = val;
        do
            @(posedge clk);
        while (in_stall);
        pending_stats.push_back(fold_sample(val));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_stats.size() != 0)
            @(negedge clk);
    endtask

    // Mean zero and a single sample first, then the field extremes and
    // large swings that push the deviation and percentage up.
    task automatic test_directed();
        logic [SAMPLE_BITS-1:0] vals[$];
        vals = '{24'h0, 24'h0, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h1, 24'h800000,
                 24'h7FFFFF, 24'hAAAAAA, 24'h555555, 24'hFFFFFF, 24'hFFFFFF,
                 24'h000001, 24'h0, 24'h123456, 24'hFFFFFE, 24'h0, 24'hFFFFFF};
        foreach (vals[i])
            send_sample(vals[i]);
        drain_results();
    endtask

    // Random samples of several shapes: full range, small values, values
    // near the top, tight clusters, and the extremes zero and full scale.
    task automatic test_random(input int idle_pct, input int stall_pct);
        logic [SAMPLE_BITS-1:0] centre;
        logic [SAMPLE_BITS-1:0] val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        centre         = SAMPLE_BITS'($urandom);
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            case ($urandom_range(4))
                0: val = SAMPLE_BITS'($urandom);
                1: val = SAMPLE_BITS'($urandom_range(255));
                2: val = 24'hFFFFFF - SAMPLE_BITS'($urandom_range(255));
                3: val = centre + SAMPLE_BITS'($urandom_range(15));
                default: val = $urandom_range(1) ? 24'h0 : 24'hFFFFFF;
            endcase
            send_sample(val);
        end
        drain_results();
    endtask

    // Receiver stalls are chosen at each falling edge.
    always @(negedge clk)
        out_stall = rst_n && ($urandom_range(99) < recv_stall_pct);

    // Result checker, sampled at the rising edge.
    always @(posedge clk)
    begin
        stats_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("unexpected result word at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                if (sample_count !== want.count)
                    report_mismatch("sample_count", sample_count, want.count);
                if (mean_value !== want.mean)
                    report_mismatch("mean_value", mean_value, want.mean);
                if (min_value !== want.min)
                    report_mismatch("min_value", min_value, want.min);
                if (max_value !== want.max)
                    report_mismatch("max_value", max_value, want.max);
                if (stddev_of_mean !== want.sd)
                    report_mismatch("stddev_of_mean", stddev_of_mean, want.sd);
                if (relative_stddev_pct !== want.pct)
                    report_mismatch("relative_stddev_pct", relative_stddev_pct, want.pct);
                if (count_saturated !== want.sat)
                    report_mismatch("count_saturated", count_saturated, want.sat);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample         = '0;
        out_stall      = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_count      = '0;
        run_mean       = '0;
        run_m2         = '0;
        run_min        = '1;
        run_max        = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(0, 0);
        test_random(51, 0);
        test_random(0, 51);
        test_random(32, 32);

        // let any stray word surface before the verdict
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/rmvs_pkg.sv
rtl/rmvs_div.sv
rtl/rmvs_mul.sv
rtl/rmvs_sqrt.sv
rtl/running_mean_variance_stats.sv
rtl/rmvs_checker.sv
verif/running_mean_variance_stats_test.sv
